// ===== rtl/lcps_pkg.sv =====
`timescale 1ns / 1ps

package lcps_pkg;

  // Register map
  localparam int unsigned CfgAddrW       = 3;
  localparam logic [0:0]  REG_FRAME_TICKS = 1'b0;
  localparam logic [15:0] FRAME_TICKS_RESET = 16'd1000;

  // Stream payload widths
  localparam int unsigned LedW       = 32;
  localparam int unsigned InTdataW   = 8;
  localparam int unsigned OutTdataW  = 40;

  // Effect codes
  localparam logic [2:0] EFF_BLINK     = 3'd0;
  localparam logic [2:0] EFF_FILL_LO   = 3'd1;
  localparam logic [2:0] EFF_FILL_HI   = 3'd2;
  localparam logic [2:0] EFF_HALF_OUT  = 3'd3;
  localparam logic [2:0] EFF_HALF_IN   = 3'd4;
  localparam logic [2:0] EFF_STACK_LO  = 3'd5;
  localparam logic [2:0] EFF_STACK_HI  = 3'd6;

  // Phase codes; anything above PHASE_HOLD is unused
  localparam logic [1:0] PHASE_FILL  = 2'd0;
  localparam logic [1:0] PHASE_CLEAR = 2'd1;
  localparam logic [1:0] PHASE_HOLD  = 2'd2;

  typedef struct packed {
    logic [2:0] effect;
    logic [5:0] outer;
    logic [5:0] inner;
    logic [1:0] phase;
  } seq_state_t;

  // n low bits set, n of 32 or more gives the full word
  function automatic logic [LedW-1:0] lo_mask(input logic [6:0] n);
    logic [LedW-1:0] m;
    m = '1;
    if (n >= 7'd32) return m;
    return ~(m << n[4:0]);
  endfunction

  // n high bits set, n of 32 or more gives the full word
  function automatic logic [LedW-1:0] hi_mask(input logic [6:0] n);
    logic [LedW-1:0] m;
    m = '1;
    if (n >= 7'd32) return m;
    return ~(m >> n[4:0]);
  endfunction

endpackage

// ===== rtl/lcps_cfg.sv =====
`timescale 1ns / 1ps

module lcps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcps_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic [15:0]                   frame_ticks_o
);

  logic [15:0] frame_ticks_q;
  logic        wr_en;
  logic        sel_ft;

  // Decode register index from the word address
  assign sel_ft = (paddr[2] == lcps_pkg::REG_FRAME_TICKS);
  assign wr_en  = psel && penable && pwrite;

  // Hold the frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_ticks_q <= lcps_pkg::FRAME_TICKS_RESET;
    end else if (wr_en && sel_ft) begin
      frame_ticks_q <= pwdata[15:0];
    end
  end

  // Read back
  assign prdata        = sel_ft ? {16'd0, frame_ticks_q} : 32'd0;
  assign frame_ticks_o = frame_ticks_q;

endmodule

// ===== rtl/lcps_seq.sv =====
`timescale 1ns / 1ps

module lcps_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic [15:0]            frame_ticks_i,
  output lcps_pkg::seq_state_t   state_o,
  output logic                   frame_start_o
);

  logic [2:0]  effect_q, effect_d;
  logic [5:0]  outer_q, outer_d;
  logic [5:0]  inner_q, inner_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] hold_q, hold_d;

  logic [15:0] limit;
  logic [16:0] hold_inc;
  logic        adv;
  logic [6:0]  outer_inc;
  logic [6:0]  inner_inc;
  logic [6:0]  span;
  logic [6:0]  room;
  logic [2:0]  effect_next;

  // Count ticks within a frame
  assign limit         = (frame_ticks_i == 16'd0) ? 16'd1 : frame_ticks_i;
  assign hold_inc      = {1'b0, hold_q} + 17'd1;
  assign adv           = tick_i && (hold_inc >= {1'b0, limit});
  assign frame_start_o = tick_i && (hold_q == 16'd0);

  assign outer_inc   = {1'b0, outer_q} + 7'd1;
  assign inner_inc   = {1'b0, inner_q} + 7'd1;
  assign room        = 7'd32 - {1'b0, outer_q};
  assign effect_next = (effect_q == lcps_pkg::EFF_STACK_HI) ? lcps_pkg::EFF_BLINK
                                                            : effect_q + 3'd1;
  assign span = (effect_q == lcps_pkg::EFF_HALF_OUT || effect_q == lcps_pkg::EFF_HALF_IN)
              ? 7'd16 : 7'd32;

  // Advance the frame sequence
  always_comb begin
    effect_d = effect_q;
    outer_d  = outer_q;
    inner_d  = inner_q;
    phase_d  = phase_q;
    hold_d   = hold_q;
    if (tick_i) begin
      hold_d = adv ? 16'd0 : hold_inc[15:0];
    end
    if (adv) begin
      if (effect_q > lcps_pkg::EFF_STACK_HI || phase_q > lcps_pkg::PHASE_HOLD) begin
        effect_d = lcps_pkg::EFF_BLINK;
        phase_d  = lcps_pkg::PHASE_FILL;
        outer_d  = 6'd0;
        inner_d  = 6'd0;
      end else if (effect_q == lcps_pkg::EFF_BLINK) begin
        if (phase_q == lcps_pkg::PHASE_FILL) begin
          phase_d = lcps_pkg::PHASE_CLEAR;
        end else begin
          effect_d = effect_next;
          phase_d  = lcps_pkg::PHASE_FILL;
          outer_d  = 6'd0;
          inner_d  = 6'd0;
        end
      end else if (effect_q <= lcps_pkg::EFF_HALF_IN) begin
        outer_d = outer_inc[5:0];
        if (outer_inc >= span) begin
          outer_d = 6'd0;
          if (phase_q == lcps_pkg::PHASE_FILL) begin
            phase_d = lcps_pkg::PHASE_CLEAR;
          end else begin
            effect_d = effect_next;
            phase_d  = lcps_pkg::PHASE_FILL;
            inner_d  = 6'd0;
          end
        end
      end else if (phase_q == lcps_pkg::PHASE_FILL) begin
        // Move the dot one place, then hold once it lands on the stack
        inner_d = inner_inc[5:0];
        if (outer_q >= 6'd32 || inner_inc >= room) begin
          inner_d = 6'd0;
          phase_d = lcps_pkg::PHASE_HOLD;
        end
      end else begin
        // Grow the stack by one and launch the next dot; a full stack holds, then the next effect starts
        outer_d = outer_inc[5:0];
        inner_d = 6'd0;
        if (outer_inc > 7'd32) begin
          effect_d = effect_next;
          phase_d  = lcps_pkg::PHASE_FILL;
          outer_d  = 6'd0;
        end else if (outer_inc == 7'd32) begin
          phase_d = lcps_pkg::PHASE_HOLD;
        end else begin
          phase_d = lcps_pkg::PHASE_FILL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_q <= lcps_pkg::EFF_BLINK;
      outer_q  <= 6'd0;
      inner_q  <= 6'd0;
      phase_q  <= lcps_pkg::PHASE_FILL;
      hold_q   <= 16'd0;
    end else begin
      effect_q <= effect_d;
      outer_q  <= outer_d;
      inner_q  <= inner_d;
      phase_q  <= phase_d;
      hold_q   <= hold_d;
    end
  end

  assign state_o = '{effect: effect_q, outer: outer_q, inner: inner_q, phase: phase_q};

  // Effect index stays within the seven effects
  a_effect_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    effect_q != 3'd7)
    else $error("effect index left the effect cycle");

  // Hold frames belong to the stacking effects only
  a_hold_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == lcps_pkg::PHASE_HOLD |->
      (effect_q == lcps_pkg::EFF_STACK_LO || effect_q == lcps_pkg::EFF_STACK_HI))
    else $error("hold phase outside stacking effect");

  // Stack and fill steps never pass a full word
  a_outer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outer_q <= 6'd32)
    else $error("outer step out of range");

  // Without a frame advance the effect does not change
  a_effect_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(effect_q))
    else $error("effect changed without frame advance");

endmodule

// ===== rtl/lcps_pattern.sv =====
`timescale 1ns / 1ps

module lcps_pattern (
  input  lcps_pkg::seq_state_t        state_i,
  output logic [lcps_pkg::LedW-1:0]   led_o
);

  logic [6:0]  l;
  logic [4:0]  m;
  logic [6:0]  k;
  logic [6:0]  l_up;
  logic        fill;
  logic [31:0] half_out;
  logic [31:0] half_in;
  logic [31:0] top_bit;

  assign l        = {1'b0, state_i.outer};
  assign l_up     = l + 7'd1;
  assign m        = state_i.inner[4:0];
  assign k        = (l > 7'd16) ? 7'd16 : l;
  assign fill     = (state_i.phase == lcps_pkg::PHASE_FILL);
  assign half_out = lcps_pkg::lo_mask(l) | lcps_pkg::hi_mask(l);
  assign half_in  = lcps_pkg::lo_mask(7'd16 + k) & ~lcps_pkg::lo_mask(7'd16 - k);
  assign top_bit  = 32'h8000_0000;

  // Select the frame pattern for the current effect and step
  always_comb begin
    led_o = '0;
    if (state_i.phase <= lcps_pkg::PHASE_HOLD) begin
      case (state_i.effect)
        lcps_pkg::EFF_BLINK:    led_o = fill ? '1 : '0;
        lcps_pkg::EFF_FILL_LO:  led_o = fill ? lcps_pkg::lo_mask(l) : ~lcps_pkg::lo_mask(l);
        lcps_pkg::EFF_FILL_HI:  led_o = fill ? lcps_pkg::hi_mask(l)
                                             : lcps_pkg::lo_mask((l >= 7'd32) ? 7'd0
                                                                               : 7'd32 - l);
        lcps_pkg::EFF_HALF_OUT: led_o = fill ? half_out : ~half_out;
        lcps_pkg::EFF_HALF_IN:  led_o = fill ? half_in : ~half_in;
        lcps_pkg::EFF_STACK_LO: led_o = (state_i.phase == lcps_pkg::PHASE_HOLD)
                                      ? lcps_pkg::lo_mask(l_up)
                                      : lcps_pkg::lo_mask(l) | (top_bit >> m);
        lcps_pkg::EFF_STACK_HI: led_o = (state_i.phase == lcps_pkg::PHASE_HOLD)
                                      ? lcps_pkg::hi_mask(l_up)
                                      : lcps_pkg::hi_mask(l) | (32'd1 << m);
        default:                led_o = '0;
      endcase
    end
  end

endmodule

// ===== rtl/led_chaser_pattern_sequencer_core.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake                     | Payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata[0] tick
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata led_word, effect_now, frame_start
// apb      | in  | psel, penable, pwrite, pready | frame_ticks at address 0
//
// One transfer in per clock while m_axis_tready does not stall it; its result is registered in the output register.
// The sequencer state and pattern decode sit between accept and that register.
// Input is taken whenever the output register is empty or being drained.
// Reset is asynchronous, active low; frame_ticks comes up at 1000.

module led_chaser_pattern_sequencer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream: [0] tick
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lcps_pkg::InTdataW-1:0]      s_axis_tdata,
  // Output stream: [31:0] led_word, [34:32] effect_now, [35] frame_start
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lcps_pkg::OutTdataW-1:0]     m_axis_tdata,
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lcps_pkg::CfgAddrW-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic                         accept;
  logic                         step;
  logic [15:0]                  frame_ticks;
  lcps_pkg::seq_state_t         state;
  logic                         frame_start;
  logic [lcps_pkg::LedW-1:0]    led;
  logic                         m_valid_q, m_valid_d;
  logic [lcps_pkg::OutTdataW-1:0] m_data_q;

  assign pready        = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step          = accept && s_axis_tdata[0];

  lcps_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .frame_ticks_o (frame_ticks)
  );

  lcps_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (step),
    .frame_ticks_i (frame_ticks),
    .state_o       (state),
    .frame_start_o (frame_start)
  );

  lcps_pattern u_pattern (
    .state_i (state),
    .led_o   (led)
  );

  // Output register valid: set on accept, drop when drained
  always_comb begin
    m_valid_d = m_valid_q;
    if (accept) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // Capture the frame shown before this tick is counted
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= {4'd0, frame_start, state.effect, led};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // An accepted transfer always shows up in the output register
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted transfer produced no result");

endmodule
